>>> sv/scs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the sparse coordinate store.
// ----------------------------------------------------------------------------
package scs_pkg;
  localparam int DEPTH_DEF      = 1024;
  localparam int COORD_BITS_DEF = 16;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 11;
  localparam int AREA_W         = 33;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PURGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_BOX,
    ST_AREA,
    ST_OUT
  } scs_state_t;
endpackage

>>> sv/scs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/sparse_coordinate_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_coordinate_store_unit
// Coordinate-list store for a sparse matrix with in-order compaction and a
// bounding-box report after every transaction.
// ----------------------------------------------------------------------------
// Each transaction runs in steps: a scan pass to find a match or to purge, a
// shift pass after a delete, a pass to rebuild the bounding box, and the area
// multiply. Only one transaction is taken at a time, so the rate is set by these
// sequential passes over the single-read-port entry RAM.
// Reset (synchronous, rst_n low) empties the store and sets the zero value
// to 0; entry memory is not cleared since only entries below the count are
// ever read.
module sparse_coordinate_store_unit
  import scs_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: func[0], row[16:1], col[32:17], value[64:33]; zero fill.
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: entry_count[10:0], min_row[26:11], max_row[42:27],
  // min_col[58:43], max_col[74:59], box_area[107:75], is_empty[108],
  // overflow[109]; zero fill.
  output logic [111:0] out_tdata
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 2 * COORD_BITS + VALUE_W;

  // Entry word layout: value in the top, column in the middle, row at bottom.
  scs_state_t state_r, state_nxt;

  logic                  func_r;
  logic [COORD_BITS-1:0] row_r, col_r;
  logic [VALUE_W-1:0]    value_r, zero_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         rd_r;      // read pointer of the current pass
  logic [CW-1:0]         wr_r;      // write pointer during compaction
  logic                  rvalid_r;  // RAM data valid for address rd_r-1
  logic                  ovf_r;
  logic [COORD_BITS-1:0] rmin_r, rmax_r, cmin_r, cmax_r;
  logic [AREA_W-1:0]     area_r;
  logic [111:0]          out_data_r;
  logic                  out_valid_r;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  scs_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [COORD_BITS-1:0] e_row, e_col;
  logic [VALUE_W-1:0]    e_val;
  assign e_row = ram_rdata[COORD_BITS-1:0];
  assign e_col = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign e_val = ram_rdata[EW-1:2*COORD_BITS];

  logic in_fire, out_fire;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // Stored coordinates are COORD_BITS wide; outputs are 16 bits.
  function automatic logic [15:0] to16(input logic [COORD_BITS-1:0] x);
    logic [COORD_BITS+15:0] w;
    w = {16'd0, x};
    return w[15:0];
  endfunction

  logic [COORD_BITS:0] dr, dc;
  logic [AREA_W-1:0]   area_prod;
  assign dr = {1'b0, rmax_r} - {1'b0, rmin_r} + {{COORD_BITS{1'b0}}, 1'b1};
  assign dc = {1'b0, cmax_r} - {1'b0, cmin_r} + {{COORD_BITS{1'b0}}, 1'b1};
  assign area_prod = AREA_W'(dr) * AREA_W'(dc);

  always_comb begin
    logic keep;
    keep      = 1'b0;
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = wr_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = rd_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A write stops at the first match; a purge compacts as it reads.
        if (rvalid_r) begin
          if (func_r == FUNC_PURGE) begin
            keep      = (e_val != value_r);
            ram_we    = keep;
            ram_waddr = wr_r[AW-1:0];
          end else if (e_row == row_r && e_col == col_r) begin
            ram_we    = (value_r != zero_r);
            ram_waddr = AW'(rd_r - CW'(1));
            ram_wdata = {value_r, col_r, row_r};
          end
        end
        if (rd_r == count_r && !rvalid_r) begin
          if (func_r == FUNC_WRITE && value_r != zero_r && count_r != CW'(DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[AW-1:0];
            ram_wdata = {value_r, col_r, row_r};
          end
        end
        if (rvalid_r && func_r == FUNC_WRITE && e_row == row_r && e_col == col_r) begin
          state_nxt = (value_r == zero_r) ? ST_SHIFT : ST_BOX;
        end else if (rd_r == count_r && !rvalid_r) begin
          state_nxt = ST_BOX;
        end
      end
      ST_SHIFT: begin
        if (rvalid_r) begin
          ram_we    = 1'b1;
          ram_waddr = wr_r[AW-1:0];
        end
        if (rd_r == count_r && (!rvalid_r || rd_r == wr_r + CW'(1))) begin
          state_nxt = ST_BOX;
        end
      end
      ST_BOX: begin
        if (rd_r == count_r && (!rvalid_r || count_r == '0)) begin
          state_nxt = ST_AREA;
        end
      end
      ST_AREA: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      zero_r      <= '0;
      out_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The result register loads in ST_OUT once the previous result is gone.
      if (state_r == ST_OUT && (!out_valid_r || out_fire)) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            func_r   <= in_tdata[0];
            row_r    <= COORD_BITS'({16'd0, in_tdata[16:1]});
            col_r    <= COORD_BITS'({16'd0, in_tdata[32:17]});
            value_r  <= in_tdata[64:33];
            rd_r     <= '0;
            wr_r     <= '0;
            rvalid_r <= 1'b0;
            ovf_r    <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (rvalid_r && func_r == FUNC_PURGE && e_val != value_r) begin
            wr_r <= wr_r + CW'(1);
          end
          if (rvalid_r && func_r == FUNC_WRITE && e_row == row_r && e_col == col_r) begin
            // Match found at rd_r-1.
            rvalid_r <= 1'b0;
            if (value_r == zero_r) begin
              wr_r <= rd_r - CW'(1);
            end else begin
              rd_r <= '0;
            end
          end else if (rd_r == count_r && !rvalid_r) begin
            if (func_r == FUNC_PURGE) begin
              count_r <= wr_r;
              zero_r  <= value_r;
            end else if (value_r != zero_r) begin
              if (count_r == CW'(DEPTH)) begin
                ovf_r <= 1'b1;
              end else begin
                count_r <= count_r + CW'(1);
              end
            end
            rd_r <= '0;
          end else if (rd_r == count_r) begin
            rvalid_r <= 1'b0;
          end else begin
            rd_r     <= rd_r + CW'(1);
            rvalid_r <= 1'b1;
          end
        end
        ST_SHIFT: begin
          // Entries after the deleted one move down by one.
          if (rvalid_r) begin
            wr_r <= wr_r + CW'(1);
          end
          if (rd_r == count_r) begin
            if (!rvalid_r || rd_r == wr_r + CW'(1)) begin
              count_r  <= count_r - CW'(1);
              rd_r     <= '0;
              rvalid_r <= 1'b0;
            end else begin
              rvalid_r <= 1'b0;
            end
          end else begin
            rd_r     <= rd_r + CW'(1);
            rvalid_r <= 1'b1;
          end
        end
        ST_BOX: begin
          if (rvalid_r) begin
            if (rd_r == CW'(1)) begin
              rmin_r <= e_row; rmax_r <= e_row;
              cmin_r <= e_col; cmax_r <= e_col;
            end else begin
              if (e_row < rmin_r) rmin_r <= e_row;
              if (e_row > rmax_r) rmax_r <= e_row;
              if (e_col < cmin_r) cmin_r <= e_col;
              if (e_col > cmax_r) cmax_r <= e_col;
            end
          end
          if (rd_r == count_r) begin
            rvalid_r <= 1'b0;
            if (count_r == '0) begin
              rmin_r <= '0; rmax_r <= '0; cmin_r <= '0; cmax_r <= '0;
            end
          end else begin
            rd_r     <= rd_r + CW'(1);
            rvalid_r <= 1'b1;
          end
        end
        ST_AREA: begin
          area_r <= (count_r == '0) ? '0 : area_prod;
        end
        ST_OUT: begin
          if (!out_valid_r || out_fire) begin
            out_data_r <= {2'b00, ovf_r, (count_r == '0), area_r, to16(cmax_r),
                           to16(cmin_r), to16(rmax_r), to16(rmin_r),
                           COUNT_W'({{COUNT_W{1'b0}}, count_r})};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule

>>> sv/scs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks of the sparse coordinate store, bound to the top level.
// ----------------------------------------------------------------------------
module scs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[108] |-> out_tdata[10:0] == 11'd0 && out_tdata[107:11] == '0)
    else $error("empty store reports a box");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  a_area_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[108] |-> out_tdata[107:75] != '0)
    else $error("nonempty store with zero area");
endmodule

bind sparse_coordinate_store_unit scs_checker u_scs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sparse_coordinate_store_unit. It sends writes,
// deletes, in-place updates and zero-value purges. A behavioral copy of the
// coordinate list predicts each status transaction, and a checker compares
// every field of every result.
// ----------------------------------------------------------------------------
module tb;
  import scs_pkg::*;

  localparam int DEPTH = 1024;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;

  sparse_coordinate_store_unit #(.DEPTH(DEPTH), .COORD_BITS(16)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic        overflow;
    logic        is_empty;
    logic [32:0] box_area;
    logic [15:0] max_col;
    logic [15:0] min_col;
    logic [15:0] max_row;
    logic [15:0] min_row;
    logic [10:0] entry_count;
  } status_t;

  // The predicted coordinate list and its current zero value.
  logic [15:0] list_rows [DEPTH];
  logic [15:0] list_cols [DEPTH];
  logic [31:0] list_vals [DEPTH];
  int          list_len;
  logic [31:0] zero_val;

  status_t expected_status [$];
  int      error_count = 0;
  bit      hold_off = 1'b0;
  bit      sender_bursty = 1'b1;

  task automatic report_mismatch(input string what, input logic [32:0] got,
                                 input logic [32:0] want);
    $display("mismatch on %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // Applies one transaction to the list and works out the status it reports.
  function automatic status_t predict_status(logic func, logic [15:0] r,
                                             logic [15:0] c, logic [31:0] v);
    status_t s;
    int hit;
    int wr;
    s = '0;
    if (func == FUNC_WRITE) begin
      hit = -1;
      for (int i = 0; i < list_len; i++)
        if (hit < 0 && list_rows[i] == r && list_cols[i] == c) hit = i;
      if (hit >= 0) begin
        if (v == zero_val) begin
          for (int k = hit; k + 1 < list_len; k++) begin
            list_rows[k] = list_rows[k+1];
            list_cols[k] = list_cols[k+1];
            list_vals[k] = list_vals[k+1];
          end
          list_len--;
        end else begin
          list_vals[hit] = v;
        end
      end else if (v != zero_val) begin
        if (list_len >= DEPTH) begin
          s.overflow = 1'b1;
        end else begin
          list_rows[list_len] = r;
          list_cols[list_len] = c;
          list_vals[list_len] = v;
          list_len++;
        end
      end
    end else begin
      wr = 0;
      for (int i = 0; i < list_len; i++)
        if (list_vals[i] != v) begin
          list_rows[wr] = list_rows[i];
          list_cols[wr] = list_cols[i];
          list_vals[wr] = list_vals[i];
          wr++;
        end
      list_len = wr;
      zero_val = v;
    end
    s.entry_count = list_len[10:0];
    s.is_empty = (list_len == 0);
    if (list_len > 0) begin
      s.min_row = list_rows[0]; s.max_row = list_rows[0];
      s.min_col = list_cols[0]; s.max_col = list_cols[0];
      for (int i = 1; i < list_len; i++) begin
        if (list_rows[i] < s.min_row) s.min_row = list_rows[i];
        if (list_rows[i] > s.max_row) s.max_row = list_rows[i];
        if (list_cols[i] < s.min_col) s.min_col = list_cols[i];
        if (list_cols[i] > s.max_col) s.max_col = list_cols[i];
      end
      s.box_area = ({17'b0, s.max_row - s.min_row} + 33'd1) *
                   ({17'b0, s.max_col - s.min_col} + 33'd1);
    end
    return s;
  endfunction

  // Sends one transaction; the expectation is queued when it is accepted.
  // Valid drops between transactions.
  task automatic send_item(input logic func, input logic [15:0] r,
                           input logic [15:0] c, input logic [31:0] v);
    if (sender_bursty && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 12)) @(negedge clk);
    else
      @(negedge clk);
    in_tdata  <= {7'b0, v, c, r, func};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_status.push_back(predict_status(func, r, c, v));
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Receiver stall pattern, with a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 9) > 2);
  end

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[109:0];
      if (expected_status.size() == 0) begin
        $display("unexpected status transaction");
        error_count++;
      end else begin
        want = expected_status.pop_front();
        if (got.entry_count != want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
        if (got.min_row != want.min_row) report_mismatch("min_row", got.min_row, want.min_row);
        if (got.max_row != want.max_row) report_mismatch("max_row", got.max_row, want.max_row);
        if (got.min_col != want.min_col) report_mismatch("min_col", got.min_col, want.min_col);
        if (got.max_col != want.max_col) report_mismatch("max_col", got.max_col, want.max_col);
        if (got.box_area != want.box_area)
          report_mismatch("box_area", got.box_area, want.box_area);
        if (got.is_empty != want.is_empty)
          report_mismatch("is_empty", got.is_empty, want.is_empty);
        if (got.overflow != want.overflow)
          report_mismatch("overflow", got.overflow, want.overflow);
      end
    end
  end

  // Extremes, delete on an empty store, update, delete, purges.
  task automatic test_directed();
    send_item(FUNC_WRITE, 16'h0001, 16'h0001, 32'h0);
    send_item(FUNC_WRITE, 16'h0000, 16'h0000, 32'h8000_0000);
    send_item(FUNC_WRITE, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(FUNC_WRITE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(FUNC_WRITE, 16'hFFFF, 16'h0000, 32'h0001_0000);
    send_item(FUNC_WRITE, 16'h0000, 16'h0000, 32'h5555_AAAA);
    send_item(FUNC_WRITE, 16'h1234, 16'h4321, 32'h0);
    send_item(FUNC_WRITE, 16'hFFFF, 16'hFFFF, 32'h0);
    send_item(FUNC_PURGE, 16'hAAAA, 16'h5555, 32'hFFFF_FFFF);
    send_item(FUNC_WRITE, 16'h0000, 16'hFFFF, 32'h0);
    send_item(FUNC_WRITE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(FUNC_PURGE, 16'h0, 16'h0, 32'h5555_AAAA);
    send_item(FUNC_PURGE, 16'h0, 16'h0, 32'h0001_0000);
    send_item(FUNC_PURGE, 16'h0, 16'h0, 32'h0);
    send_item(FUNC_WRITE, 16'h0010, 16'h0020, 32'h0);
  endtask

  // Random traffic over a small coordinate pool so that hits are common.
  task automatic test_random(input int count);
    logic [15:0] r;
    logic [15:0] c;
    logic [31:0] v;
    for (int n = 0; n < count; n++) begin
      r = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      c = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0: v = zero_val;
        1: v = (list_len > 0) ? list_vals[$urandom_range(0, list_len - 1)] : $urandom;
        2: v = 32'($urandom_range(1, 3));
        default: v = $urandom;
      endcase
      send_item(($urandom_range(0, 19) == 0) ? FUNC_PURGE : FUNC_WRITE, r, c, v);
    end
  endtask

  // Fill the store to capacity, then try appends, updates and a delete.
  task automatic test_full_store();
    send_item(FUNC_PURGE, 16'h0, 16'h0, 32'h0);
    for (int i = 0; i < DEPTH; i++)
      send_item(FUNC_WRITE, 16'(i), 16'(i * 3), 32'(i + 1));
    send_item(FUNC_WRITE, 16'hFFFF, 16'h0000, 32'h7);
    send_item(FUNC_WRITE, 16'd5, 16'd15, 32'h9);
    send_item(FUNC_WRITE, 16'd7, 16'd21, 32'h0);
    send_item(FUNC_WRITE, 16'hFFFF, 16'h0000, 32'h7);
    send_item(FUNC_WRITE, 16'hFFFE, 16'h0001, 32'h8);
    send_item(FUNC_PURGE, 16'h0, 16'h0, 32'h9);
    send_item(FUNC_PURGE, 16'h0, 16'h0, 32'h0);
  endtask

  // The receiver holds off while the sender keeps offering transactions.
  // The hold-off ends from its own counting process, so the stalled sender
  // can finish once results drain.
  task automatic test_backpressure();
    hold_off = 1'b1;
    sender_bursty = 1'b0;
    fork
      test_random(6);
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    sender_bursty = 1'b1;
  endtask

  initial begin
    list_len = 0;
    zero_val = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(150);
    test_backpressure();
    test_full_store();
    test_random(130);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end
endmodule

>>> sim.f
sv/scs_pkg.sv
sv/scs_ram.sv
sv/sparse_coordinate_store_unit.sv
sv/scs_checker.sv
verif/tb.sv
